[rtl/aplc_pkg.sv]
package aplc_pkg;

    // Transaction field types
    typedef logic [1:0]  op_t;
    typedef logic [2:0]  status_t;
    typedef logic [15:0] line_t;
    typedef logic [2:0]  slot_t;

    // Operation codes
    localparam op_t OP_ACCESS = 2'd0;
    localparam op_t OP_AGE    = 2'd1;
    localparam op_t OP_FLUSH  = 2'd2;

    // Result status codes
    localparam status_t ST_HIT     = 3'd0;
    localparam status_t ST_FILL    = 3'd1;
    localparam status_t ST_REPLACE = 3'd2;
    localparam status_t ST_BYPASS  = 3'd3;
    localparam status_t ST_NONE    = 3'd4;

    // Tag value that marks an empty slot, and the priority of a new entry
    localparam line_t EMPTY_TAG    = 16'hFFFF;
    localparam int    NEW_PRIORITY = 2;

endpackage

[rtl/aging_priority_line_cache.sv]
// Fully associative line cache with aging priorities.
// Command channel: a transaction (op, line_number) is taken on a rising edge with
// start high and busy low. busy stays low, so a command can be issued every cycle.
// Ops: access looks up line_number (hit bumps priority, miss fills the lowest empty
// slot, else replaces the lowest zero-priority entry, else bypasses), age decrements
// all nonzero priorities, flush empties every slot; while disabled, access bypasses.
// Result channel: result_valid is high for exactly one cycle with status, slot and
// evicted_line; the receiver cannot hold results off, so there is no stall path.
// Pipeline: input register, one pass of parallel tag compare and priority encoding,
// then the result register that drives result_valid and the result fields.
// Throughput: one command per cycle; each command sees the state left by the one
// before it, since state and result are written on the same edge.
// Config channel: cfg_data bit 0 is cache_enable, written when cfg_valid and
// cfg_ready are high; cfg_ready is always high. Write it only while idle.
// Reset: all slots empty, priorities zero, cache disabled, no result pending.
module aging_priority_line_cache #(
    parameter int ENTRIES       = 8,
    parameter int PRIORITY_BITS = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  aplc_pkg::op_t   op,
    input  aplc_pkg::line_t line_number,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_data,
    output logic            result_valid,
    output aplc_pkg::status_t status,
    output aplc_pkg::slot_t slot,
    output aplc_pkg::line_t evicted_line
);
    import aplc_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [PRIORITY_BITS-1:0] PRIO_MAX = '1;
    localparam logic [PRIORITY_BITS-1:0] PRIO_NEW = PRIORITY_BITS'(NEW_PRIORITY);

    // Input register
    logic      in_valid_reg;
    op_t       in_op_reg;
    line_t     in_line_reg;

    // Configuration
    logic      enable_reg;

    // Cache state
    line_t                    tag_reg  [ENTRIES];
    line_t                    tag_next [ENTRIES];
    logic [PRIORITY_BITS-1:0] prio_reg [ENTRIES];
    logic [PRIORITY_BITS-1:0] prio_next[ENTRIES];

    // Result register
    logic      out_valid_reg;
    status_t   status_reg;
    status_t   status_next;
    slot_t     slot_reg;
    slot_t     slot_next;
    line_t     evict_reg;
    line_t     evict_next;

    // Match vectors and lowest-index encoders
    logic [ENTRIES-1:0] hit_vec;
    logic [ENTRIES-1:0] empty_vec;
    logic [ENTRIES-1:0] zero_vec;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   empty_idx;
    logic [IDX_W-1:0]   zero_idx;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Parallel tag compare
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i]   = (tag_reg[i] == in_line_reg);
            empty_vec[i] = (tag_reg[i] == EMPTY_TAG);
            zero_vec[i]  = (prio_reg[i] == '0);
        end
    end

    // Lowest set index of each vector
    always_comb
    begin
        hit_idx   = '0;
        empty_idx = '0;
        zero_idx  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
                hit_idx = IDX_W'(i);
            if (empty_vec[i])
                empty_idx = IDX_W'(i);
            if (zero_vec[i])
                zero_idx = IDX_W'(i);
        end
    end

    // Command execution
    always_comb
    begin
        tag_next    = tag_reg;
        prio_next   = prio_reg;
        status_next = ST_NONE;
        slot_next   = '0;
        evict_next  = '0;
        if (in_valid_reg)
        begin
            if (!enable_reg)
            begin
                status_next = (in_op_reg == OP_ACCESS) ? ST_BYPASS : ST_NONE;
            end
            else
            begin
                case (in_op_reg)
                    OP_ACCESS:
                    begin
                        if (in_line_reg == EMPTY_TAG)
                        begin
                            status_next = ST_BYPASS;
                        end
                        else if (|hit_vec)
                        begin
                            if (prio_reg[hit_idx] != PRIO_MAX)
                                prio_next[hit_idx] = prio_reg[hit_idx] + 1'b1;
                            status_next = ST_HIT;
                            slot_next   = slot_t'(hit_idx);
                        end
                        else if (|empty_vec)
                        begin
                            tag_next[empty_idx]  = in_line_reg;
                            prio_next[empty_idx] = PRIO_NEW;
                            status_next          = ST_FILL;
                            slot_next            = slot_t'(empty_idx);
                        end
                        else if (|zero_vec)
                        begin
                            evict_next          = tag_reg[zero_idx];
                            tag_next[zero_idx]  = in_line_reg;
                            prio_next[zero_idx] = PRIO_NEW;
                            status_next         = ST_REPLACE;
                            slot_next           = slot_t'(zero_idx);
                        end
                        else
                        begin
                            status_next = ST_BYPASS;
                        end
                    end
                    OP_AGE:
                    begin
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            if (!empty_vec[i] && !zero_vec[i])
                                prio_next[i] = prio_reg[i] - 1'b1;
                        end
                    end
                    OP_FLUSH:
                    begin
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            tag_next[i]  = EMPTY_TAG;
                            prio_next[i] = '0;
                        end
                    end
                    default:
                    begin
                        status_next = ST_NONE;
                    end
                endcase
            end
        end
    end

    // Control and cache state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            enable_reg    <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                tag_reg[i]  <= EMPTY_TAG;
                prio_reg[i] <= '0;
            end
        end
        else
        begin
            in_valid_reg  <= start && !busy;
            out_valid_reg <= in_valid_reg;
            if (cfg_valid && cfg_ready)
                enable_reg <= cfg_data;
            tag_reg  <= tag_next;
            prio_reg <= prio_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_op_reg   <= op;
            in_line_reg <= line_number;
        end
        status_reg <= status_next;
        slot_reg   <= slot_next;
        evict_reg  <= evict_next;
    end

    assign result_valid = out_valid_reg;
    assign status       = status_reg;
    assign slot         = slot_reg;
    assign evicted_line = evict_reg;

endmodule

[rtl/aplc_checker.sv]
module aplc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input aplc_pkg::op_t     op,
    input logic              result_valid,
    input aplc_pkg::status_t status,
    input aplc_pkg::slot_t   slot,
    input aplc_pkg::line_t   evicted_line
);
    import aplc_pkg::*;

    logic accept;
    assign accept = start && !busy;

    // Every accepted command yields a result once it has passed the input and result registers
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 result_valid)
        else $error("accepted command produced no result");

    // No result without a command behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(accept, 2))
        else $error("result without an accepted command");

    // Age, flush and unused ops never look anything up
    a_non_access: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op != OP_ACCESS) |-> ##2 (status == ST_NONE))
        else $error("non-access command reported a lookup");

    // Bypass and no-lookup results carry zero slot and zero evicted line
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status == ST_BYPASS || status == ST_NONE))
            |-> (slot == '0 && evicted_line == '0))
        else $error("nonzero fields on bypass or no-lookup result");

    // Evicted line shows only on a replacement
    a_evict_only_replace: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != ST_REPLACE) |-> (evicted_line == '0))
        else $error("evicted line outside a replacement");

endmodule

bind aging_priority_line_cache aplc_checker u_aplc_checker (.*);

[bench/tb_aging_priority_line_cache.sv]
`timescale 1ns / 1ps

module tb_aging_priority_line_cache;

    import aplc_pkg::*;

    localparam int CACHE_ENTRIES  = 8;
    localparam int PRIO_BITS      = 8;
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int POOL_SIZE      = 13;

    // op code 3 has no meaning in the block; it must answer "no lookup"
    localparam op_t OP_UNUSED = 2'd3;

    localparam logic [PRIO_BITS-1:0] PRIO_MAX = {PRIO_BITS{1'b1}};

    typedef struct packed {
        op_t   op;
        line_t line_num;
    } cache_cmd_t;

    typedef struct packed {
        status_t status;
        slot_t   slot;
        line_t   evicted;
    } lookup_result_t;

    logic    clk         = 1'b0;
    logic    rst_n       = 1'b0;
    logic    start       = 1'b0;
    op_t     op          = OP_ACCESS;
    line_t   line_number = '0;
    logic    cfg_valid   = 1'b0;
    logic    cfg_data    = 1'b0;
    logic    busy;
    logic    cfg_ready;
    logic    result_valid;
    status_t status;
    slot_t   slot;
    line_t   evicted_line;

    // Commands waiting to be issued, and lookup results still to come back
    cache_cmd_t     cmd_queue[$];
    lookup_result_t expected_results[$];

    // Shadow copy of the cache contents and the enable register
    line_t                cache_tag[CACHE_ENTRIES];
    logic [PRIO_BITS-1:0] cache_prio[CACHE_ENTRIES];
    logic                 cache_on = 1'b0;

    int    sender_idle_pct = 0;
    int    mismatches      = 0;
    int    quiet_cycles    = 0;
    line_t line_pool[POOL_SIZE];

    aging_priority_line_cache dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .line_number  (line_number),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .status       (status),
        .slot         (slot),
        .evicted_line (evicted_line)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            cache_tag[i]  = EMPTY_TAG;
            cache_prio[i] = '0;
        end
    end

    // Apply one command to the shadow cache and return the lookup result
    function automatic lookup_result_t predict_lookup(op_t c_op, line_t c_line);
        lookup_result_t r;
        int hit_idx;
        int empty_idx;
        int zero_idx;
        r.status  = ST_NONE;
        r.slot    = '0;
        r.evicted = '0;
        hit_idx   = -1;
        empty_idx = -1;
        zero_idx  = -1;
        if (!cache_on)
        begin
            r.status = (c_op == OP_ACCESS) ? ST_BYPASS : ST_NONE;
        end
        else if (c_op == OP_ACCESS)
        begin
            if (c_line == EMPTY_TAG)
            begin
                // the empty marker can never be cached
                r.status = ST_BYPASS;
            end
            else
            begin
                for (int i = 0; i < CACHE_ENTRIES; i++)
                begin
                    if (hit_idx < 0 && cache_tag[i] == c_line)
                        hit_idx = i;
                    if (empty_idx < 0 && cache_tag[i] == EMPTY_TAG)
                        empty_idx = i;
                    if (zero_idx < 0 && cache_prio[i] == '0)
                        zero_idx = i;
                end
                if (hit_idx >= 0)
                begin
                    if (cache_prio[hit_idx] != PRIO_MAX)
                        cache_prio[hit_idx] = cache_prio[hit_idx] + 1'b1;
                    r.status = ST_HIT;
                    r.slot   = slot_t'(hit_idx);
                end
                else if (empty_idx >= 0)
                begin
                    cache_tag[empty_idx]  = c_line;
                    cache_prio[empty_idx] = PRIO_BITS'(NEW_PRIORITY);
                    r.status = ST_FILL;
                    r.slot   = slot_t'(empty_idx);
                end
                else if (zero_idx >= 0)
                begin
                    r.evicted            = cache_tag[zero_idx];
                    cache_tag[zero_idx]  = c_line;
                    cache_prio[zero_idx] = PRIO_BITS'(NEW_PRIORITY);
                    r.status = ST_REPLACE;
                    r.slot   = slot_t'(zero_idx);
                end
                else
                begin
                    r.status = ST_BYPASS;
                end
            end
        end
        else if (c_op == OP_AGE)
        begin
            for (int i = 0; i < CACHE_ENTRIES; i++)
                if (cache_tag[i] != EMPTY_TAG && cache_prio[i] != '0)
                    cache_prio[i] = cache_prio[i] - 1'b1;
        end
        else if (c_op == OP_FLUSH)
        begin
            for (int i = 0; i < CACHE_ENTRIES; i++)
            begin
                cache_tag[i]  = EMPTY_TAG;
                cache_prio[i] = '0;
            end
        end
        return r;
    endfunction

    // Driver: predict on each accepted transaction, then issue the next command
    always @(posedge clk)
    begin
        cache_cmd_t next_cmd;
        logic       issue;
        if (cfg_valid && cfg_ready)
            cache_on = cfg_data;
        if (start && !busy)
            expected_results.push_back(predict_lookup(op, line_number));
        if (!start || !busy)
        begin
            issue = (cmd_queue.size() != 0) && ($urandom_range(99) >= sender_idle_pct);
            if (issue)
            begin
                next_cmd    = cmd_queue.pop_front();
                start       <= 1'b1;
                op          <= next_cmd.op;
                line_number <= next_cmd.line_num;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: each result strobe is checked against the oldest prediction
    always @(posedge clk)
    begin
        lookup_result_t want;
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: status %0d slot %0d evicted %h",
                             status, slot, evicted_line);
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status || slot !== want.slot ||
                    evicted_line !== want.evicted)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("result mismatch: status exp %0d got %0d, slot exp %0d got %0d",
                                 want.status, status, want.slot, slot);
                        $display("    evicted exp %h got %h", want.evicted, evicted_line);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_cmd(op_t c_op, line_t c_line);
        cache_cmd_t c;
        c.op       = c_op;
        c.line_num = c_line;
        cmd_queue.push_back(c);
    endtask

    // Wait until every command is accepted and every result is back
    task automatic wait_drained();
        while (cmd_queue.size() != 0 || start || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write cache_enable, then set the sender's idle rate and a fresh line pool
    task automatic begin_phase(logic enable, int idle_pct);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= enable;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge clk);
        sender_idle_pct = idle_pct;
        line_pool[0] = 16'h0000;
        line_pool[1] = 16'hFFFE;
        line_pool[2] = 16'h8000;
        line_pool[3] = EMPTY_TAG;
        for (int i = 4; i < POOL_SIZE; i++)
            line_pool[i] = line_t'($urandom_range(16'hFFFE));
    endtask

    // Random traffic: mostly accesses to a working set a bit larger than the
    // cache, mixed with aging bursts, rare flushes and noise
    task automatic gen_random(int count);
        int n;
        int pick;
        int len;
        n = 0;
        while (n < count)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                len = $urandom_range(8, 1);
                repeat (len)
                    push_cmd(OP_ACCESS, line_pool[$urandom_range(POOL_SIZE - 1)]);
            end
            else if (pick < 75)
            begin
                len = $urandom_range(3, 1);
                repeat (len)
                    push_cmd(OP_AGE, line_t'($urandom));
            end
            else if (pick < 79)
            begin
                len = 1;
                push_cmd(OP_FLUSH, line_t'($urandom));
            end
            else if (pick < 90)
            begin
                len = 1;
                push_cmd(op_t'($urandom_range(3)), line_t'($urandom));
            end
            else
            begin
                len = 1;
                push_cmd(OP_ACCESS, line_t'($urandom));
            end
            n += len;
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Cache disabled: every op is a no-op
        begin_phase(1'b0, 34);
        push_cmd(OP_ACCESS, 16'h0000);
        push_cmd(OP_ACCESS, EMPTY_TAG);
        push_cmd(OP_AGE, 16'h0000);
        push_cmd(OP_FLUSH, 16'hFFFE);
        push_cmd(OP_UNUSED, EMPTY_TAG);
        push_cmd(OP_ACCESS, 16'hFFFE);
        gen_random(100);
        wait_drained();

        // Cache enabled: fill, hit, reserved tag, full bypass, aging, replace
        begin_phase(1'b1, 34);
        push_cmd(OP_ACCESS, 16'h0000);
        push_cmd(OP_ACCESS, 16'hFFFE);
        push_cmd(OP_ACCESS, 16'h0000);
        push_cmd(OP_ACCESS, EMPTY_TAG);
        push_cmd(OP_ACCESS, 16'h5555);
        push_cmd(OP_ACCESS, 16'hAAAA);
        push_cmd(OP_ACCESS, 16'h00FF);
        push_cmd(OP_ACCESS, 16'hFF00);
        push_cmd(OP_ACCESS, 16'h0001);
        push_cmd(OP_ACCESS, 16'h7FFF);
        push_cmd(OP_ACCESS, 16'h1234);
        push_cmd(OP_AGE, 16'h0000);
        push_cmd(OP_AGE, 16'hFFFF);
        push_cmd(OP_ACCESS, 16'h1234);
        push_cmd(OP_ACCESS, 16'hFFFE);
        push_cmd(OP_UNUSED, 16'hFFFF);
        push_cmd(OP_FLUSH, 16'h0000);
        push_cmd(OP_ACCESS, 16'hFFFE);
        push_cmd(OP_AGE, 16'hFFFF);
        gen_random(400);
        wait_drained();

        // Disabled again with contents held, then re-enabled
        begin_phase(1'b0, 82);
        gen_random(80);
        wait_drained();
        begin_phase(1'b1, 82);
        gen_random(300);
        wait_drained();

        // Back-to-back: drive one entry to saturation, then random traffic
        begin_phase(1'b1, 0);
        push_cmd(OP_FLUSH, 16'h0000);
        repeat (260)
            push_cmd(OP_ACCESS, 16'hC3A5);
        push_cmd(OP_AGE, 16'h0000);
        push_cmd(OP_ACCESS, 16'hC3A5);
        gen_random(100);
        wait_drained();

        mismatches += expected_results.size();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
rtl/aplc_pkg.sv
rtl/aging_priority_line_cache.sv
rtl/aplc_checker.sv
bench/tb_aging_priority_line_cache.sv
